// ----- hdl/gss_pkg.sv -----
// gss_pkg: shared types and constants of the GOP structure statistics block.
// Used by every module under hdl/. No dependencies.

package gss_pkg;

    localparam int IDX_W         = 32;  // unit index and interval field width
    localparam int STAT_W        = 40;  // statistic value field width
    localparam int KIND_W        = 3;
    localparam int CODE_W        = 4;
    localparam int MASK_W        = 5;
    localparam int NUM_KINDS     = 6;
    localparam int AVG_FRAC_BITS = 8;   // average interval is unsigned Q8
    localparam int QUEUE_DEPTH   = 2;

    // unit kinds
    localparam logic [KIND_W-1:0] KIND_P     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_B     = 3'd1;
    localparam logic [KIND_W-1:0] KIND_I     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SP    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SI    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_MIXED = 3'd5;

    // statistic codes
    localparam logic [CODE_W-1:0] STAT_TOTAL   = 4'd0;
    localparam logic [CODE_W-1:0] STAT_KIND_P  = 4'd1;
    localparam logic [CODE_W-1:0] STAT_KIND_B  = 4'd2;
    localparam logic [CODE_W-1:0] STAT_KIND_I  = 4'd3;
    localparam logic [CODE_W-1:0] STAT_KIND_SP = 4'd4;
    localparam logic [CODE_W-1:0] STAT_KIND_SI = 4'd5;
    localparam logic [CODE_W-1:0] STAT_KIND_MX = 4'd6;
    localparam logic [CODE_W-1:0] STAT_LEADING = 4'd7;
    localparam logic [CODE_W-1:0] STAT_COUNT   = 4'd8;
    localparam logic [CODE_W-1:0] STAT_MIN     = 4'd9;
    localparam logic [CODE_W-1:0] STAT_MAX     = 4'd10;
    localparam logic [CODE_W-1:0] STAT_SUM     = 4'd11;
    localparam logic [CODE_W-1:0] STAT_AVG     = 4'd12;

    // input function codes
    localparam logic FUNC_UNIT   = 1'b0;
    localparam logic FUNC_REPORT = 1'b1;

    // classified command passed from front end to back end
    typedef struct packed {
        logic              is_report;
        logic [KIND_W-1:0] kind;
        logic              idr;
        logic [IDX_W-1:0]  index;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } back_state_t;

endpackage

// ----- hdl/gss_front.sv -----
// gss_front: input stage; takes a transaction, classifies the slice-type mask
// and holds the command until the queue takes it. Depends on gss_pkg.

module gss_front (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_func,
    input  logic [gss_pkg::MASK_W-1:0] s_slice_types,
    input  logic                       s_is_idr,
    input  logic [gss_pkg::IDX_W-1:0]  s_unit_index,
    output logic                       push_valid,
    input  logic                       push_ready,
    output gss_pkg::cmd_t              push_data
);
    import gss_pkg::*;

    logic  vld_reg, vld_next;
    cmd_t  cmd_reg, cmd_next;
    logic  [KIND_W-1:0] kind;
    logic  [2:0] ones;
    logic  [KIND_W-1:0] which;

    // single type present -> that kind, otherwise mixed
    always_comb begin
        ones  = '0;
        which = KIND_P;
        for (int b = 0; b < MASK_W; b++) begin
            if (s_slice_types[b]) begin
                ones  = ones + 3'd1;
                which = KIND_W'(b);
            end
        end
        kind = (ones == 3'd1) ? which : KIND_MIXED;
    end

    assign s_ready    = !vld_reg || push_ready;
    assign push_valid = vld_reg;
    assign push_data  = cmd_reg;

    always_comb begin
        vld_next = vld_reg;
        cmd_next = cmd_reg;
        if (vld_reg && push_ready) begin
            vld_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            vld_next           = 1'b1;
            cmd_next.is_report = (s_func == FUNC_REPORT);
            cmd_next.kind      = kind;
            cmd_next.idr       = s_is_idr;
            cmd_next.index     = s_unit_index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
    end

endmodule

// ----- hdl/gss_queue.sv -----
// gss_queue: short command FIFO between front end and back end.
// Depends on gss_pkg (cmd_t, QUEUE_DEPTH).

module gss_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  gss_pkg::cmd_t wr_data,
    output logic          rd_valid,
    input  logic          rd_pop,
    output gss_pkg::cmd_t rd_data
);
    import gss_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push, pop;

    assign wr_ready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ----- hdl/gss_div.sv -----
// gss_div: restoring divider, one quotient bit per cycle, for the Q8 average.
// Depends on gss_pkg (AVG_FRAC_BITS).

module gss_div #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            start,
    input  logic [COUNT_WIDTH+gss_pkg::AVG_FRAC_BITS-1:0]   dividend,
    input  logic [COUNT_WIDTH-1:0]                          divisor,
    output logic                                            done,
    output logic [COUNT_WIDTH+gss_pkg::AVG_FRAC_BITS-1:0]   quotient
);
    import gss_pkg::*;

    localparam int QW    = COUNT_WIDTH + AVG_FRAC_BITS;
    localparam int CNT_W = $clog2(QW + 1);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [COUNT_WIDTH-1:0] rem_reg, rem_next;
    logic [COUNT_WIDTH-1:0] dvs_reg, dvs_next;
    logic [QW-1:0]          dq_reg, dq_next;
    logic [COUNT_WIDTH:0]   trial, diff;
    logic                   ge;

    // partial remainder shifted with the next dividend bit
    assign trial = {rem_reg, dq_reg[QW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        dq_next   = dq_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(QW);
            rem_next  = '0;
            dvs_next  = divisor;
            dq_next   = dividend;
        end else if (busy_reg) begin
            rem_next = ge ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
            dq_next  = {dq_reg[QW-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        dq_reg  <= dq_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// ----- hdl/gss_back.sv -----
// gss_back: statistics engine; pops commands, updates the counters, builds
// unit results and sequences the report. Depends on gss_pkg; drives gss_div.

module gss_back #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          q_valid,
    output logic                                          q_pop,
    input  gss_pkg::cmd_t                                 q_data,
    output logic                                          div_start,
    output logic [COUNT_WIDTH+gss_pkg::AVG_FRAC_BITS-1:0] div_dividend,
    output logic [COUNT_WIDTH-1:0]                        div_divisor,
    input  logic                                          div_done,
    input  logic [COUNT_WIDTH+gss_pkg::AVG_FRAC_BITS-1:0] div_quotient,
    output logic                                          m_valid,
    input  logic                                          m_ready,
    output logic [gss_pkg::KIND_W-1:0]                    m_unit_kind,
    output logic                                          m_idr_flag,
    output logic [gss_pkg::IDX_W-1:0]                     m_idr_index,
    output logic [gss_pkg::IDX_W-1:0]                     m_idr_interval,
    output logic [gss_pkg::CODE_W-1:0]                    m_stat_code,
    output logic [gss_pkg::STAT_W-1:0]                    m_stat_value,
    output logic                                          m_last
);
    import gss_pkg::*;

    localparam int CW = COUNT_WIDTH;
    localparam int QW = COUNT_WIDTH + AVG_FRAC_BITS;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                              input logic [CW-1:0] b);
        logic [CW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CW] ? {CW{1'b1}} : s[CW-1:0];
    endfunction

    back_state_t state_reg, state_next;

    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] kcnt_reg [NUM_KINDS];
    logic [CW-1:0] kcnt_next [NUM_KINDS];
    logic [CW-1:0] lead_reg, lead_next;
    logic          seen_reg, seen_next;
    logic [CW-1:0] lastpos_reg, lastpos_next;
    logic [CW-1:0] icnt_reg, icnt_next;
    logic [CW-1:0] imin_reg, imin_next;
    logic [CW-1:0] imax_reg, imax_next;
    logic [CW-1:0] isum_reg, isum_next;
    logic [QW-1:0] avg_reg, avg_next;
    logic [CODE_W-1:0] code_reg, code_next;

    logic                m_valid_reg, m_valid_next;
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic                idr_reg, idr_next;
    logic [IDX_W-1:0]    index_reg, index_next;
    logic [IDX_W-1:0]    ival_reg, ival_next;
    logic [CODE_W-1:0]   scode_reg, scode_next;
    logic [STAT_W-1:0]   sval_reg, sval_next;
    logic                last_reg, last_next;

    logic          out_free;
    logic [CW-1:0] interval;
    logic [63:0]   ival_wide;
    logic [63:0]   stat_wide;

    assign out_free     = !m_valid_reg || m_ready;
    assign div_dividend = {isum_reg, {AVG_FRAC_BITS{1'b0}}};
    assign div_divisor  = icnt_reg;
    assign interval     = lastpos_reg <= total_reg ? total_reg - lastpos_reg : '0;
    assign ival_wide    = 64'(interval);

    // statistic selected by the report sequencer
    always_comb begin
        unique case (code_reg)
            STAT_TOTAL:   stat_wide = 64'(total_reg);
            STAT_KIND_P:  stat_wide = 64'(kcnt_reg[KIND_P]);
            STAT_KIND_B:  stat_wide = 64'(kcnt_reg[KIND_B]);
            STAT_KIND_I:  stat_wide = 64'(kcnt_reg[KIND_I]);
            STAT_KIND_SP: stat_wide = 64'(kcnt_reg[KIND_SP]);
            STAT_KIND_SI: stat_wide = 64'(kcnt_reg[KIND_SI]);
            STAT_KIND_MX: stat_wide = 64'(kcnt_reg[KIND_MIXED]);
            STAT_LEADING: stat_wide = seen_reg ? 64'(lead_reg) : 64'(total_reg);
            STAT_COUNT:   stat_wide = 64'(icnt_reg);
            STAT_MIN:     stat_wide = (icnt_reg != '0) ? 64'(imin_reg) : 64'd0;
            STAT_MAX:     stat_wide = (icnt_reg != '0) ? 64'(imax_reg) : 64'd0;
            STAT_SUM:     stat_wide = (icnt_reg != '0) ? 64'(isum_reg) : 64'd0;
            STAT_AVG:     stat_wide = 64'(avg_reg);
            default:      stat_wide = 64'd0;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        total_next   = total_reg;
        kcnt_next    = kcnt_reg;
        lead_next    = lead_reg;
        seen_next    = seen_reg;
        lastpos_next = lastpos_reg;
        icnt_next    = icnt_reg;
        imin_next    = imin_reg;
        imax_next    = imax_reg;
        isum_next    = isum_reg;
        avg_next     = avg_reg;
        code_next    = code_reg;

        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        idr_next     = idr_reg;
        index_next   = index_reg;
        ival_next    = ival_reg;
        scode_next   = scode_reg;
        sval_next    = sval_reg;
        last_next    = last_reg;

        q_pop     = 1'b0;
        div_start = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    if (q_data.is_report) begin
                        code_next = STAT_TOTAL;
                        if (icnt_reg != '0) begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end else begin
                            avg_next   = '0;
                            state_next = ST_EMIT;
                        end
                    end else begin
                        // unit: position is the total before counting it
                        for (int k = 0; k < NUM_KINDS; k++) begin
                            if (q_data.kind == KIND_W'(k)) begin
                                kcnt_next[k] = sat_inc(kcnt_reg[k]);
                            end
                        end
                        total_next = sat_inc(total_reg);
                        ival_next  = '0;
                        if (q_data.idr) begin
                            if (!seen_reg) begin
                                lead_next = total_reg;
                                seen_next = 1'b1;
                            end else begin
                                ival_next = (ival_wide[63:IDX_W] != '0) ? {IDX_W{1'b1}}
                                                                        : ival_wide[IDX_W-1:0];
                                if (icnt_reg == '0) begin
                                    imin_next = interval;
                                    imax_next = interval;
                                end else begin
                                    if (interval < imin_reg) imin_next = interval;
                                    if (interval > imax_reg) imax_next = interval;
                                end
                                icnt_next = sat_inc(icnt_reg);
                                isum_next = sat_add(isum_reg, interval);
                            end
                            lastpos_next = total_reg;
                        end
                        m_valid_next = 1'b1;
                        kind_next    = q_data.kind;
                        idr_next     = q_data.idr;
                        index_next   = q_data.idr ? q_data.index : '0;
                        scode_next   = STAT_TOTAL;
                        sval_next    = '0;
                        last_next    = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    avg_next   = div_quotient;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    kind_next    = KIND_P;
                    idr_next     = 1'b0;
                    index_next   = '0;
                    ival_next    = '0;
                    scode_next   = code_reg;
                    sval_next    = (stat_wide[63:STAT_W] != '0) ? {STAT_W{1'b1}}
                                                                : stat_wide[STAT_W-1:0];
                    last_next    = (code_reg == STAT_AVG);
                    if (code_reg == STAT_AVG) begin
                        // report done: clear the counters and interval statistics
                        total_next   = '0;
                        for (int k = 0; k < NUM_KINDS; k++) begin
                            kcnt_next[k] = '0;
                        end
                        lead_next    = '0;
                        seen_next    = 1'b0;
                        lastpos_next = '0;
                        icnt_next    = '0;
                        imin_next    = '0;
                        imax_next    = '0;
                        isum_next    = '0;
                        state_next   = ST_IDLE;
                    end else begin
                        code_next = code_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg   <= '0;
            for (int k = 0; k < NUM_KINDS; k++) begin
                kcnt_reg[k] <= '0;
            end
            lead_reg    <= '0;
            seen_reg    <= 1'b0;
            lastpos_reg <= '0;
            icnt_reg    <= '0;
            imin_reg    <= '0;
            imax_reg    <= '0;
            isum_reg    <= '0;
            code_reg    <= STAT_TOTAL;
            m_valid_reg <= 1'b0;
        end else begin
            total_reg   <= total_next;
            kcnt_reg    <= kcnt_next;
            lead_reg    <= lead_next;
            seen_reg    <= seen_next;
            lastpos_reg <= lastpos_next;
            icnt_reg    <= icnt_next;
            imin_reg    <= imin_next;
            imax_reg    <= imax_next;
            isum_reg    <= isum_next;
            code_reg    <= code_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        avg_reg   <= avg_next;
        kind_reg  <= kind_next;
        idr_reg   <= idr_next;
        index_reg <= index_next;
        ival_reg  <= ival_next;
        scode_reg <= scode_next;
        sval_reg  <= sval_next;
        last_reg  <= last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_unit_kind    = kind_reg;
    assign m_idr_flag     = idr_reg;
    assign m_idr_index    = index_reg;
    assign m_idr_interval = ival_reg;
    assign m_stat_code    = scode_reg;
    assign m_stat_value   = sval_reg;
    assign m_last         = last_reg;

    a_pop_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> out_free)
        else $error("command popped while result register occupied");

    a_min_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (icnt_reg != '0) |-> (imin_reg <= imax_reg))
        else $error("interval minimum above maximum");

    a_lead_le_total: assert property (@(posedge aclk) disable iff (!aresetn)
        seen_reg |-> (lead_reg <= total_reg))
        else $error("leading count beyond unit total");

    a_emit_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (code_reg <= STAT_AVG))
        else $error("report sequencer ran past last statistic");

    a_clear_after_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT && out_free && code_reg == STAT_AVG)
            |=> (total_reg == '0 && icnt_reg == '0 && !seen_reg))
        else $error("statistics not cleared after report");

endmodule

// ----- hdl/gop_structure_statistics.sv -----
// gop_structure_statistics: top level of the GOP structure statistics block.
// Depends on gss_pkg, gss_front, gss_queue, gss_div and gss_back.
//
// Usage
//   Input channel (s_*): one transaction per access unit (s_func = 0) with its
//   slice-type mask, IDR flag and stream index, or a report request
//   (s_func = 1). Result channel (m_*): one transaction per unit carrying its
//   kind and IDR interval (m_last set), or 13 statistic transactions per report,
//   codes 0..12, m_last on the Q8 average. All counters saturate.
//   Path: a unit result passes the front-end holding register, the queue and
//   the result register. A report runs the restoring divider (skipped when
//   no interval has been seen), then issues its 13 statistics one a cycle
//   while m_ready is high.
//   Throughput: one unit per cycle while m_ready is high, the back end
//   updating its counters as it pops the unit; while a report is under way
//   the front end accepts until its holding register and two-entry queue fill.
//   Stalls: when m_ready is low the result register holds, the back end stops
//   popping, and back-pressure reaches s_ready through the queue.
//   Reset (aresetn low, synchronous): all statistics are zero, queue and
//   result register empty; no clearing pass is needed.

module gop_structure_statistics #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_func,
    input  logic [gss_pkg::MASK_W-1:0] s_slice_types,
    input  logic                       s_is_idr,
    input  logic [gss_pkg::IDX_W-1:0]  s_unit_index,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [gss_pkg::KIND_W-1:0] m_unit_kind,
    output logic                       m_idr_flag,
    output logic [gss_pkg::IDX_W-1:0]  m_idr_index,
    output logic [gss_pkg::IDX_W-1:0]  m_idr_interval,
    output logic [gss_pkg::CODE_W-1:0] m_stat_code,
    output logic [gss_pkg::STAT_W-1:0] m_stat_value,
    output logic                       m_last
);
    import gss_pkg::*;

    localparam int QW = COUNT_WIDTH + AVG_FRAC_BITS;

    // front end -> queue
    logic push_valid, push_ready;
    cmd_t push_data;

    // queue -> back end
    logic q_valid, q_pop;
    cmd_t q_data;

    // back end <-> divider
    logic                   div_start, div_done;
    logic [QW-1:0]          div_dividend, div_quotient;
    logic [COUNT_WIDTH-1:0] div_divisor;

    gss_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_slice_types (s_slice_types),
        .s_is_idr      (s_is_idr),
        .s_unit_index  (s_unit_index),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    gss_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_data)
    );

    // Q8 average: sum * 256 / interval count
    gss_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    gss_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_data         (q_data),
        .div_start      (div_start),
        .div_dividend   (div_dividend),
        .div_divisor    (div_divisor),
        .div_done       (div_done),
        .div_quotient   (div_quotient),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_unit_kind    (m_unit_kind),
        .m_idr_flag     (m_idr_flag),
        .m_idr_index    (m_idr_index),
        .m_idr_interval (m_idr_interval),
        .m_stat_code    (m_stat_code),
        .m_stat_value   (m_stat_value),
        .m_last         (m_last)
    );

endmodule

// ----- tb/sv/tb.sv -----
// tb: self-checking testbench for gop_structure_statistics.
// Depends on gss_pkg and the RTL under hdl/. It predicts every result transaction
// of the block and checks the results under random sender and receiver idling.
`timescale 1ns / 1ps

module tb;
    import gss_pkg::*;

    localparam int COUNT_WIDTH = 32;
    // Cycles without any transaction before the run is declared hung. The
    // slowest stretch is a report divide followed by a long receiver stall,
    // so this leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 5000;
    // Quiet cycles after the last expected result, to catch stray ones.
    localparam int TAIL_CYCLES = 2 * COUNT_WIDTH + 48;
    localparam int MAX_REPORTED = 10;

    localparam logic [63:0] CNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;
    localparam logic [63:0] IDX_MAX = (64'd1 << IDX_W) - 64'd1;
    localparam logic [63:0] STAT_MAX_VAL = (64'd1 << STAT_W) - 64'd1;

    // One result transaction as seen on the m_ side
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              idr;
        logic [IDX_W-1:0]  index;
        logic [IDX_W-1:0]  interval;
        logic [CODE_W-1:0] code;
        logic [STAT_W-1:0] value;
        logic              last;
    } gop_result_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic                s_func        = FUNC_UNIT;
    logic [MASK_W-1:0]   s_slice_types = '0;
    logic                s_is_idr      = 1'b0;
    logic [IDX_W-1:0]    s_unit_index  = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [KIND_W-1:0]   m_unit_kind;
    logic                m_idr_flag;
    logic [IDX_W-1:0]    m_idr_index;
    logic [IDX_W-1:0]    m_idr_interval;
    logic [CODE_W-1:0]   m_stat_code;
    logic [STAT_W-1:0]   m_stat_value;
    logic                m_last;

    // Idle rates in percent, changed between phases
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // Bookkeeping
    gop_result_t expected_results[$];
    int          mismatches     = 0;
    int          results_checked = 0;
    int          units_sent     = 0;
    int          reports_sent   = 0;
    int          stall_cycles   = 0;

    // Predicted statistics state, counters held wider than COUNT_WIDTH
    logic [63:0] unit_count;
    logic [63:0] kind_tally [NUM_KINDS];
    logic [63:0] lead_units;
    logic        seen_idr;
    logic [63:0] prev_idr_pos;
    logic [63:0] gap_count;
    logic [63:0] gap_min;
    logic [63:0] gap_max;
    logic [63:0] gap_sum;

    gop_structure_statistics #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_slice_types (s_slice_types),
        .s_is_idr      (s_is_idr),
        .s_unit_index  (s_unit_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_unit_kind   (m_unit_kind),
        .m_idr_flag    (m_idr_flag),
        .m_idr_index   (m_idr_index),
        .m_idr_interval(m_idr_interval),
        .m_stat_code   (m_stat_code),
        .m_stat_value  (m_stat_value),
        .m_last        (m_last)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [63:0] sat_inc(input logic [63:0] v);
        return (v >= CNT_MAX) ? CNT_MAX : v + 64'd1;
    endfunction

    function automatic logic [63:0] clamp_to(input logic [63:0] v, input logic [63:0] hi);
        return (v > hi) ? hi : v;
    endfunction

    // Exactly one slice type present gives that kind; none or several is mixed
    function automatic logic [KIND_W-1:0] classify_mask(input logic [MASK_W-1:0] mask);
        unique case (mask)
            5'b00001: return KIND_P;
            5'b00010: return KIND_B;
            5'b00100: return KIND_I;
            5'b01000: return KIND_SP;
            5'b10000: return KIND_SI;
            default:  return KIND_MIXED;
        endcase
    endfunction

    function automatic string fmt_result(input gop_result_t r);
        return $sformatf("kind=%0d idr=%0b idx=%h int=%0d code=%0d val=%0d last=%0b",
                         r.kind, r.idr, r.index, r.interval, r.code, r.value, r.last);
    endfunction

    // Appends one predicted result at the tail of the expected list
    task automatic append_expected(input gop_result_t r);
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic clear_gop_stats();
        unit_count   = '0;
        foreach (kind_tally[k]) kind_tally[k] = '0;
        lead_units   = '0;
        seen_idr     = 1'b0;
        prev_idr_pos = '0;
        gap_count    = '0;
        gap_min      = '0;
        gap_max      = '0;
        gap_sum      = '0;
    endtask

    task automatic queue_stat(input logic [CODE_W-1:0] code, input logic [63:0] value);
        gop_result_t r;
        r          = '0;
        r.code     = code;
        r.value    = clamp_to(value, STAT_MAX_VAL);
        r.last     = (code == STAT_AVG);
        append_expected(r);
    endtask

    // Works out the results of one accepted input transaction
    task automatic predict_gop_results(input logic func, input logic [MASK_W-1:0] mask,
                                       input logic idr, input logic [IDX_W-1:0] index);
        gop_result_t       r;
        logic [KIND_W-1:0] kind;
        logic [63:0]       pos;
        logic [63:0]       gap;
        logic [63:0]       avg;
        if (func == FUNC_UNIT) begin
            kind = classify_mask(mask);
            pos  = unit_count;
            gap  = '0;
            kind_tally[kind] = sat_inc(kind_tally[kind]);
            unit_count       = sat_inc(unit_count);
            if (idr) begin
                if (!seen_idr) begin
                    // first IDR: closes the leading run, no interval yet
                    lead_units = pos;
                    seen_idr   = 1'b1;
                end else begin
                    gap = pos - prev_idr_pos;
                    if (gap_count == 0) begin
                        gap_min = gap;
                        gap_max = gap;
                    end else begin
                        if (gap < gap_min) gap_min = gap;
                        if (gap > gap_max) gap_max = gap;
                    end
                    gap_count = sat_inc(gap_count);
                    gap_sum   = clamp_to(gap_sum + gap, CNT_MAX);
                end
                prev_idr_pos = pos;
            end
            r          = '0;
            r.kind     = kind;
            r.idr      = idr;
            r.index    = idr ? index : '0;
            r.interval = clamp_to(gap, IDX_MAX);
            r.last     = 1'b1;
            append_expected(r);
        end else begin
            queue_stat(STAT_TOTAL,   unit_count);
            queue_stat(STAT_KIND_P,  kind_tally[KIND_P]);
            queue_stat(STAT_KIND_B,  kind_tally[KIND_B]);
            queue_stat(STAT_KIND_I,  kind_tally[KIND_I]);
            queue_stat(STAT_KIND_SP, kind_tally[KIND_SP]);
            queue_stat(STAT_KIND_SI, kind_tally[KIND_SI]);
            queue_stat(STAT_KIND_MX, kind_tally[KIND_MIXED]);
            // with no IDR yet every unit so far counts as leading
            queue_stat(STAT_LEADING, seen_idr ? lead_units : unit_count);
            queue_stat(STAT_COUNT,   gap_count);
            // interval figures read as zero until an interval exists
            avg = (gap_count != 0) ? (gap_sum << AVG_FRAC_BITS) / gap_count : '0;
            queue_stat(STAT_MIN, (gap_count != 0) ? gap_min : 64'd0);
            queue_stat(STAT_MAX, (gap_count != 0) ? gap_max : 64'd0);
            queue_stat(STAT_SUM, (gap_count != 0) ? gap_sum : 64'd0);
            queue_stat(STAT_AVG, avg);
            clear_gop_stats();
        end
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Presents one transaction, idling first at the current sender rate, and
    // returns at the edge where it is accepted. Valid is left high so that
    // back-to-back transactions need no second assignment in one step.
    task automatic send_item(input logic func, input logic [MASK_W-1:0] mask,
                             input logic idr, input logic [IDX_W-1:0] index);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= func;
        s_slice_types <= mask;
        s_is_idr      <= idr;
        s_unit_index  <= index;
        do @(posedge aclk); while (!s_ready);
        predict_gop_results(func, mask, idr, index);
        if (func == FUNC_UNIT) units_sent++;
        else reports_sent++;
    endtask

    task automatic send_unit(input logic [MASK_W-1:0] mask, input logic idr,
                             input logic [IDX_W-1:0] index);
        send_item(FUNC_UNIT, mask, idr, index);
    endtask

    // Report with junk in the ignored fields
    task automatic send_report();
        send_item(FUNC_REPORT, MASK_W'($urandom), 1'($urandom), $urandom);
    endtask

    // Holds the input side off until every expected result has come back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Output side: receiver stalls and result checking
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        gop_result_t got;
        gop_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_unit_kind, m_idr_flag, m_idr_index, m_idr_interval,
                    m_stat_code, m_stat_value, m_last};
            results_checked++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("[%0t] unexpected result: %s", $realtime, fmt_result(got));
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTED) begin
                        $display("[%0t] mismatch: expected %s", $realtime, fmt_result(want));
                        $display("[%0t]           actual   %s", $realtime, fmt_result(got));
                    end
                end
            end
        end
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Watchdog: any transaction on either side resets the count
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Report straight after reset: every statistic zero
    task automatic test_reset_report();
        send_report();
    endtask

    // Each single slice type, then the mixed forms (none, all, two), no IDR;
    // the report then shows the leading count equal to the total
    task automatic test_unit_kinds();
        send_unit(5'b00001, 1'b0, 32'd1);
        send_unit(5'b00010, 1'b0, 32'd2);
        send_unit(5'b00100, 1'b0, 32'd3);
        send_unit(5'b01000, 1'b0, 32'd4);
        send_unit(5'b10000, 1'b0, 32'd5);
        send_unit(5'b00000, 1'b0, 32'd6);
        send_unit(5'b11111, 1'b0, 32'd7);
        send_unit(5'b00011, 1'b0, 32'd8);
        send_report();
    endtask

    // First IDR at position 0, then intervals of 2, 1 and 1 with index extremes;
    // the average comes out fractional in Q8
    task automatic test_idr_intervals();
        send_unit(5'b00100, 1'b1, 32'h0000_0000);
        send_unit(5'b00001, 1'b0, 32'h1234_5678);
        send_unit(5'b00010, 1'b1, 32'hFFFF_FFFF);
        send_unit(5'b00100, 1'b1, 32'h5555_5555);
        send_unit(5'b11111, 1'b1, 32'hAAAA_AAAA);
        send_item(FUNC_REPORT, 5'b11111, 1'b1, 32'hFFFF_FFFF);
    endtask

    // Mostly well-formed streams: single-type units with IDRs now and then,
    // a sprinkling of mixed masks and the odd report. Ends with a report so
    // the phase's statistics are always read back.
    task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct);
        int              pick;
        int              idr_pct;
        logic [MASK_W-1:0] mask;
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        idr_pct     = 20;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                send_report();
            end else begin
                // GOP length drifts so both short and long intervals appear
                if ($urandom_range(0, 15) == 0) idr_pct = $urandom_range(3, 60);
                pick = $urandom_range(0, 99);
                if (pick < 70)      mask = MASK_W'(1) << $urandom_range(0, MASK_W - 1);
                else if (pick < 92) mask = MASK_W'($urandom);
                else if (pick < 96) mask = '0;
                else                mask = '1;
                send_unit(mask, $urandom_range(0, 99) < idr_pct, $urandom);
            end
        end
        send_report();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        clear_gop_stats();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part under the first idling pattern
        tx_idle_pct = 18;
        rx_idle_pct = 68;
        test_reset_report();
        test_unit_kinds();
        test_idr_intervals();

        // random part: slow receiver, then slow sender, then no idling;
        // the sender drains the block completely between phases
        test_random_traffic(52, 18, 68);
        wait_for_results();
        test_random_traffic(52, 68, 18);
        wait_for_results();
        test_random_traffic(45, 0, 0);
        wait_for_results();

        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d access units and %0d reports under three idling patterns.",
                 units_sent, reports_sent);
        $display("%0d result transactions checked, %0d mismatches.",
                 results_checked, mismatches);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/gss_pkg.sv
hdl/gss_front.sv
hdl/gss_queue.sv
hdl/gss_div.sv
hdl/gss_back.sv
hdl/gop_structure_statistics.sv
tb/sv/tb.sv
